// File: rtl/core/cubic_bezier_color_path_macros.svh
// Assertion macros for the cubic Bezier colour path checkers.
`ifndef CUBIC_BEZIER_COLOR_PATH_MACROS_SVH
`define CUBIC_BEZIER_COLOR_PATH_MACROS_SVH

// Concurrent assertion on a named clock, disabled while the named reset is low.
`define CBCP_ASSERT_RST(lbl, clk_sig, rstn_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) else $error(msg);

// The same on the usual clk and rst_n of the enclosing module.
`define CBCP_ASSERT(lbl, prop, msg) \
  `CBCP_ASSERT_RST(lbl, clk, rst_n, prop, msg)

`endif

// File: rtl/core/cbcp_pkg.sv
// Package with types, constants and the weight table of the Bezier colour path.
`default_nettype none

package cbcp_pkg;

  localparam int CURVE_POINTS = 15;
  localparam int MAX_POINTS   = 64;
  localparam int QUEUE_DEPTH  = 2;
  localparam int CH_LEVELS    = 15;
  // Largest Bernstein weight is MAX_POINTS cubed, which needs this many bits.
  localparam int WGT_MAX_W    = 19;

  typedef logic [3:0] chan_t;

  typedef struct packed {
    chan_t p1_red;
    chan_t p1_green;
    chan_t p1_blue;
    chan_t p2_red;
    chan_t p2_green;
    chan_t p2_blue;
    chan_t p3_red;
    chan_t p3_green;
    chan_t p3_blue;
    chan_t p4_red;
    chan_t p4_green;
    chan_t p4_blue;
  } cbcp_in_t;

  typedef struct packed {
    chan_t out_red;
    chan_t out_green;
    chan_t out_blue;
    logic  last_point;
  } cbcp_out_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  // Head of the curve queue as seen by the sampler.
  typedef struct packed {
    logic     valid;
    cbcp_in_t pts;
  } cbcp_head_t;

  // Four weights of one sample: (N-i)^3, 3i(N-i)^2, 3i^2(N-i), i^3.
  typedef logic [3:0][WGT_MAX_W-1:0] wset_t;
  typedef wset_t [MAX_POINTS:0] wtab_t;

  function automatic wtab_t cbcp_weight_table(input int n);
    wtab_t t;
    int    r;
    t = '0;
    for (int i = 0; i <= MAX_POINTS; i++) begin
      if (i <= n) begin
        r       = n - i;
        t[i][0] = WGT_MAX_W'(r * r * r);
        t[i][1] = WGT_MAX_W'(3 * i * r * r);
        t[i][2] = WGT_MAX_W'(3 * i * i * r);
        t[i][3] = WGT_MAX_W'(i * i * i);
      end
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/cbcp_in_if.sv
// Interface of the control point channel.
`default_nettype none

interface cbcp_in_if import cbcp_pkg::*; ();
  logic     valid;
  logic     ready;
  cbcp_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/cbcp_out_if.sv
// Interface of the sampled point channel.
`default_nettype none

interface cbcp_out_if import cbcp_pkg::*; ();
  logic      valid;
  logic      ready;
  cbcp_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/cubic_bezier_color_path.sv
// Top level of the cubic Bezier colour path sampler.
//
//   channel  direction  payload                                    transaction
//   in_ch    sink       four RGB control points, 4 bits a channel  one curve
//   out_ch   source     one RGB sample and its last_point flag     one curve point
//
// A curve produces N_POINTS samples from the sample sequencer, one a cycle while
// out_ch does not stall; the queue can take the next curve meanwhile.
// With the back end idle, each repeat of the opening point of a curve delays the
// first result of that curve.
// Reset is synchronous and active low; it empties the queue and the pipeline.
// A stall on out_ch freezes the whole back end; the front queue keeps taking
// transactions until its QUEUE_DEPTH entries are full.
`default_nettype none

module cubic_bezier_color_path import cbcp_pkg::*; #(
  parameter int N_POINTS    = CURVE_POINTS,
  parameter int QUEUE_DEPTH = cbcp_pkg::QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cbcp_in_if.sink     in_ch,
  cbcp_out_if.source  out_ch
);

  // Curves wait here until the sampler has finished the one before.
  cbcp_head_t head;
  logic       pop;

  cbcp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .pop   (pop),
    .head  (head)
  );

  // The sampler steps i from 1 to N_POINTS over the head curve, weights the
  // control points with a constant Bernstein table, rounds each channel and
  // removes repeated points before the output register.
  cbcp_sampler #(
    .N_POINTS (N_POINTS)
  ) u_sampler (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// File: rtl/core/cbcp_queue.sv
// Front end: a short queue of accepted curves waiting for the sampler.
`default_nettype none

module cbcp_queue import cbcp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cbcp_in_if.sink     in_ch,
  input  wire logic   pop,
  output cbcp_head_t  head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cbcp_in_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push;

  assign in_ch.ready = (cnt_r != CNT_W'(DEPTH));
  assign push        = in_ch.valid && in_ch.ready;

  assign head.valid = (cnt_r != '0);
  assign head.pts   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_ch.data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/cbcp_sampler.sv
// Back end: sample sequencer, weighting pipeline, rounding and duplicate removal.
`default_nettype none

module cbcp_sampler import cbcp_pkg::*; #(
  parameter int N_POINTS = CURVE_POINTS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cbcp_head_t  head,
  output logic             pop,
  cbcp_out_if.source       out_ch
);

  localparam int    DEN   = N_POINTS * N_POINTS * N_POINTS;
  localparam int    WGT_W = $clog2(DEN + 1);
  localparam int    NUM_W = WGT_W + 4;
  localparam int    IDX_W = $clog2(N_POINTS + 1);
  localparam int    TAB_W = $clog2(MAX_POINTS + 1);
  localparam wtab_t WTAB  = cbcp_weight_table(N_POINTS);

  logic             adv;
  logic             issue;
  logic             at_end;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // Stage 1: control points and weights of the sample.
  logic             s1_valid_r;
  cbcp_in_t         s1_pts_r;
  logic [WGT_W-1:0] s1_w_r [4];
  logic             s1_last_r;

  // Stage 2: weighted control points.
  logic [3:0]       cp [3][4];
  logic [NUM_W-1:0] prod_nxt [3][4];
  logic             s2_valid_r;
  logic [NUM_W-1:0] s2_prod_r [3][4];
  logic             s2_last_r;

  // Stage 3: numerators.
  logic [NUM_W-1:0] num_nxt [3];
  logic             s3_valid_r;
  logic [NUM_W-1:0] s3_num_r [3];
  logic             s3_last_r;

  // Stage 4: rounded colour.
  logic [3:0]       lvl [3];
  rgb_t             rgb_nxt;
  logic             s4_valid_r;
  rgb_t             s4_rgb_r;
  logic             s4_last_r;

  // Hold stage and output register.
  logic             hd_valid_r, hd_valid_nxt;
  rgb_t             hd_rgb_r, hd_rgb_nxt;
  logic             hd_last_r, hd_last_nxt;
  logic             emit;
  logic             out_valid_r, out_valid_nxt;
  cbcp_out_t        out_data_r, out_data_nxt;

  assign adv    = !out_valid_r || out_ch.ready;
  assign issue  = adv && head.valid;
  assign at_end = (idx_r == IDX_W'(N_POINTS));
  assign pop    = issue && at_end;

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_comb begin
    idx_nxt = idx_r;
    if (issue) begin
      idx_nxt = at_end ? IDX_W'(1) : idx_r + 1'b1;
    end
  end

  always_comb begin
    cp[0][0] = s1_pts_r.p1_red;
    cp[1][0] = s1_pts_r.p1_green;
    cp[2][0] = s1_pts_r.p1_blue;
    cp[0][1] = s1_pts_r.p2_red;
    cp[1][1] = s1_pts_r.p2_green;
    cp[2][1] = s1_pts_r.p2_blue;
    cp[0][2] = s1_pts_r.p3_red;
    cp[1][2] = s1_pts_r.p3_green;
    cp[2][2] = s1_pts_r.p3_blue;
    cp[0][3] = s1_pts_r.p4_red;
    cp[1][3] = s1_pts_r.p4_green;
    cp[2][3] = s1_pts_r.p4_blue;
    for (int c = 0; c < 3; c++) begin
      for (int j = 0; j < 4; j++) begin
        prod_nxt[c][j] = NUM_W'(cp[c][j]) * NUM_W'(s1_w_r[j]);
      end
    end
  end

  // The weights sum to N^3, so the numerator never exceeds fifteen times that.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num_nxt[c] = s2_prod_r[c][0] + s2_prod_r[c][1] + s2_prod_r[c][2] + s2_prod_r[c][3];
    end
  end

  // Round half up against fixed thresholds: level k is reached when
  // 2*num >= N^3*(2k-1). Fifteen levels at most gives the saturation.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lvl[c] = '0;
      for (int k = 0; k < CH_LEVELS; k++) begin
        lvl[c] = lvl[c] + 4'({s3_num_r[c], 1'b0} >= (NUM_W + 1)'(DEN * (2 * k + 1)));
      end
    end
    rgb_nxt.red   = lvl[0];
    rgb_nxt.green = lvl[1];
    rgb_nxt.blue  = lvl[2];
  end

  // The held point goes out once a differing sample arrives or once it is
  // known to close its curve; a sample equal to it is dropped.
  always_comb begin
    hd_valid_nxt = hd_valid_r;
    hd_rgb_nxt   = hd_rgb_r;
    hd_last_nxt  = hd_last_r;
    emit         = 1'b0;
    if (hd_valid_r && hd_last_r) begin
      emit         = 1'b1;
      hd_valid_nxt = s4_valid_r;
      hd_rgb_nxt   = s4_rgb_r;
      hd_last_nxt  = s4_last_r;
    end else if (s4_valid_r) begin
      if (hd_valid_r && (s4_rgb_r == hd_rgb_r)) begin
        hd_last_nxt = s4_last_r;
      end else begin
        emit         = hd_valid_r;
        hd_valid_nxt = 1'b1;
        hd_rgb_nxt   = s4_rgb_r;
        hd_last_nxt  = s4_last_r;
      end
    end
    out_valid_nxt           = emit;
    out_data_nxt.out_red    = hd_rgb_r.red;
    out_data_nxt.out_green  = hd_rgb_r.green;
    out_data_nxt.out_blue   = hd_rgb_r.blue;
    out_data_nxt.last_point = hd_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= IDX_W'(1);
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      hd_valid_r  <= 1'b0;
      hd_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      idx_r       <= idx_nxt;
      s1_valid_r  <= head.valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      hd_valid_r  <= hd_valid_nxt;
      hd_last_r   <= hd_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pts_r   <= head.pts;
      s1_last_r  <= at_end;
      for (int j = 0; j < 4; j++) begin
        s1_w_r[j] <= WTAB[TAB_W'(idx_r)][j][WGT_W-1:0];
      end
      s2_prod_r  <= prod_nxt;
      s2_last_r  <= s1_last_r;
      s3_num_r   <= num_nxt;
      s3_last_r  <= s2_last_r;
      s4_rgb_r   <= rgb_nxt;
      s4_last_r  <= s3_last_r;
      hd_rgb_r   <= hd_rgb_nxt;
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/cbcp_checker.sv
// Port checker for the cubic Bezier colour path, bound to the top level.
`default_nettype none
`include "cubic_bezier_color_path_macros.svh"

module cbcp_checker import cbcp_pkg::*; #(
  parameter int N_POINTS = CURVE_POINTS
) (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire cbcp_out_t out_data
);

  logic       in_acc;
  logic       out_acc;
  logic       have_prev_r;
  logic [11:0] prev_rgb_r;
  logic [7:0] cnt_r;
  logic [7:0] pend_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      cnt_r       <= '0;
      pend_r      <= '0;
    end else begin
      if (out_acc) begin
        have_prev_r <= !out_data.last_point;
        cnt_r       <= out_data.last_point ? 8'd0 : cnt_r + 8'd1;
      end
      case ({in_acc, out_acc && out_data.last_point})
        2'b10:   pend_r <= pend_r + 8'd1;
        2'b01:   pend_r <= pend_r - 8'd1;
        default: pend_r <= pend_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      prev_rgb_r <= {out_data.out_red, out_data.out_green, out_data.out_blue};
    end
  end

  `CBCP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")
  `CBCP_ASSERT(a_no_repeat, out_acc && have_prev_r |-> {out_data.out_red, out_data.out_green, out_data.out_blue} != prev_rgb_r, "repeated point within a curve")
  `CBCP_ASSERT(a_run_length, out_acc |-> cnt_r < 8'(N_POINTS), "too many points in one curve")
  `CBCP_ASSERT(a_no_orphan, out_valid |-> pend_r != 8'd0, "result without an open curve")

endmodule

bind cubic_bezier_color_path cbcp_checker #(
  .N_POINTS (N_POINTS)
) u_cbcp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire

// File: dv/cubic_bezier_color_path_tb.sv
// Self-checking testbench for the cubic Bezier colour path sampler.
module cubic_bezier_color_path_tb import cbcp_pkg::*; ();

  // Number of samples taken along each curve; the block is built with the same value.
  localparam int N_SAMPLES = CURVE_POINTS;
  // The transaction count at which the sampled point channel is held off for a long stretch.
  localparam int HOLD_AT = 200;
  localparam int HOLD_CYCLES = 400;
  // Beyond this many mismatches only the count goes on, to keep the log short.
  localparam int REPORT_CAP = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cbcp_in_if  in_ch ();
  cbcp_out_if out_ch ();

  cubic_bezier_color_path #(
    .N_POINTS(N_SAMPLES)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // Curves waiting to be offered, and the sampled points that the accepted curves must give,
  // oldest first.
  cbcp_in_t  curve_queue[$];
  cbcp_out_t expected_samples[$];

  int curves_taken = 0;
  int mismatches = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  cbcp_out_t want;

  // One channel of one sample: the Bernstein-weighted sum of the four control values over
  // N cubed, rounded half up and clamped to the 4-bit range.  Everything fits in an int.
  function automatic chan_t bezier_level(input int a, input int b, input int c, input int d,
                                         input int i);
    int r;
    int den;
    int num;
    int v;
    r   = N_SAMPLES - i;
    den = N_SAMPLES * N_SAMPLES * N_SAMPLES;
    num = a * r * r * r + 3 * b * i * r * r + 3 * c * i * i * r + d * i * i * i;
    v   = (2 * num + den) / (2 * den);
    if (v > 15) v = 15;
    return chan_t'(v);
  endfunction

  // Appends one point to the tail of the expected results.
  task automatic expect_sample(input cbcp_out_t s);
    expected_samples.insert(expected_samples.size(), s);
  endtask

  // Walks the curve from the first sample after the start point to the end point.  A sample
  // is held back until the next different colour shows up, so that consecutive duplicates are
  // dropped and the one still held at the end is the one that carries the last_point flag.
  task automatic predict_curve(input cbcp_in_t c);
    rgb_t      cur;
    cbcp_out_t held;
    bit        holding;
    holding = 1'b0;
    held    = '0;
    for (int i = 1; i <= N_SAMPLES; i++) begin
      cur.red   = bezier_level(c.p1_red, c.p2_red, c.p3_red, c.p4_red, i);
      cur.green = bezier_level(c.p1_green, c.p2_green, c.p3_green, c.p4_green, i);
      cur.blue  = bezier_level(c.p1_blue, c.p2_blue, c.p3_blue, c.p4_blue, i);
      if (!holding || cur != {held.out_red, held.out_green, held.out_blue}) begin
        if (holding) expect_sample(held);
        held    = {cur.red, cur.green, cur.blue, 1'b0};
        holding = 1'b1;
      end
    end
    held.last_point = 1'b1;
    expect_sample(held);
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_CAP) $display("%0t: mismatch: %s", $time, what);
  endtask

  task automatic queue_curve(input rgb_t a, input rgb_t b, input rgb_t c, input rgb_t d);
    curve_queue.insert(curve_queue.size(), {a, b, c, d});
  endtask

  function automatic rgb_t any_colour();
    return rgb_t'($urandom_range(0, 4095));
  endfunction

  function automatic chan_t nudge(input chan_t c);
    int v;
    v = int'(c) + int'($urandom_range(0, 2)) - 1;
    if (v < 0) v = 0;
    if (v > 15) v = 15;
    return chan_t'(v);
  endfunction

  // Idling percentages move through three traffic phases as transactions are accepted: a
  // slow receiver first, then a slow sender, then free-running traffic on both sides.
  function automatic int idle_pct(input bit receiver);
    if (curves_taken < 90) return receiver ? 77 : 29;
    if (curves_taken < 180) return receiver ? 29 : 77;
    return 0;
  endfunction

  // Driver: retires the transaction accepted at this edge, predicting its samples, and puts
  // the next curve on the channel whenever the current one is gone or none was offered.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      in_ch.data   <= '0;
      curves_taken <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_curve(in_ch.data);
        curves_taken <= curves_taken + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (curve_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= curve_queue.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off on the result side, started once in the free-running phase.  The sender keeps
  // offering curves, so the front queue fills and the block has to refuse input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && curves_taken >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: every sampled point transaction is checked against the oldest expectation, field
  // by field; then ready is chosen for the next cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("unexpected sample %h", out_ch.data));
        end else begin
          want = expected_samples.pop_front();
          if (out_ch.data.out_red !== want.out_red)
            report_mismatch($sformatf("out_red %h, expected %h",
                                      out_ch.data.out_red, want.out_red));
          if (out_ch.data.out_green !== want.out_green)
            report_mismatch($sformatf("out_green %h, expected %h",
                                      out_ch.data.out_green, want.out_green));
          if (out_ch.data.out_blue !== want.out_blue)
            report_mismatch($sformatf("out_blue %h, expected %h",
                                      out_ch.data.out_blue, want.out_blue));
          if (out_ch.data.last_point !== want.last_point)
            report_mismatch($sformatf("last_point %b, expected %b",
                                      out_ch.data.last_point, want.last_point));
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct(1'b1));
    end
  end

  // Stimulus and end of test.  Colours are written as 12-bit red-green-blue hex values.
  initial begin
    rgb_t base;
    int   kind;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;

    // Directed curves: extremes, flat curves giving a single point, loops that leave a colour
    // and come back to it (so a colour is emitted again after a different one), and single
    // channels moving on their own.
    queue_curve(12'h000, 12'h000, 12'h000, 12'h000);
    queue_curve(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    queue_curve(12'h000, 12'h000, 12'hFFF, 12'hFFF);
    queue_curve(12'hFFF, 12'h000, 12'h000, 12'h000);
    queue_curve(12'h000, 12'h000, 12'h000, 12'hFFF);
    queue_curve(12'h000, 12'hFFF, 12'hFFF, 12'h000);
    queue_curve(12'hFFF, 12'h000, 12'h000, 12'hFFF);
    queue_curve(12'h000, 12'hFFF, 12'h000, 12'hFFF);
    queue_curve(12'h0F0, 12'hF0F, 12'h0F0, 12'hF0F);
    queue_curve(12'h777, 12'h777, 12'h888, 12'h888);
    queue_curve(12'h5A3, 12'h5A3, 12'h5A3, 12'h5A3);
    queue_curve(12'h9C4, 12'h2E7, 12'hB16, 12'h000);
    queue_curve(12'h000, 12'h500, 12'hA00, 12'hF00);
    queue_curve(12'h000, 12'h050, 12'h0A0, 12'h0F0);
    queue_curve(12'h000, 12'h005, 12'h00A, 12'h00F);
    queue_curve(12'hFFF, 12'h000, 12'hFFF, 12'h000);

    // Random curves: mostly unconstrained, with a share of closed loops, near-flat curves that
    // produce many dropped duplicates, and straight lines.
    repeat (254) begin
      kind = $urandom_range(0, 9);
      base = any_colour();
      if (kind <= 5) begin
        queue_curve(base, any_colour(), any_colour(), any_colour());
      end else if (kind <= 7) begin
        queue_curve(base, any_colour(), any_colour(), base);
      end else if (kind == 8) begin
        queue_curve(base, {nudge(base.red), nudge(base.green), nudge(base.blue)},
                    {nudge(base.red), nudge(base.green), nudge(base.blue)},
                    {nudge(base.red), nudge(base.green), nudge(base.blue)});
      end else begin
        rgb_t tip;
        tip = any_colour();
        queue_curve(base, base, tip, tip);
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Everything offered, accepted and answered; then a margin for stray samples.
    @(posedge clk);
    while (curve_queue.size() != 0 || in_ch.valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/cbcp_pkg.sv
rtl/core/cbcp_in_if.sv
rtl/core/cbcp_out_if.sv
rtl/core/cbcp_queue.sv
rtl/core/cbcp_sampler.sv
rtl/core/cubic_bezier_color_path.sv
rtl/core/cbcp_checker.sv
dv/cubic_bezier_color_path_tb.sv
